/* src/sct_pkg.sv */
// ---------------------------------------------------------------------------
// sct_pkg: shared types, constants and character-class functions
// Token type codes, lexer mode codes and helpers for the tokenizer.
// ---------------------------------------------------------------------------
package sct_pkg;

	localparam int LineBitsDefault = 16;
	localparam int ColumnBitsDefault = 16;
	localparam int LengthBitsDefault = 16;
	localparam int KeywordMaxLenDefault = 6;

	localparam int KeywordCount = 17;

	localparam logic [5:0] TOK_NUMBER = 6'd17;
	localparam logic [5:0] TOK_STRING = 6'd18;
	localparam logic [5:0] TOK_IDENT = 6'd19;
	localparam logic [5:0] TOK_ARROW = 6'd24;
	localparam logic [5:0] TOK_EOF = 6'd46;
	localparam logic [5:0] TOK_NONE = 6'd63;
	localparam logic [5:0] TOK_COMMENT = 6'd62;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF = 1'b1;
	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_PEND = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_IDENT = 3'd3,
		MODE_STRING = 3'd4,
		MODE_ESC = 3'd5,
		MODE_COMMENT = 3'd6,
		MODE_DONE = 3'd7
	} mode_t;

	// A result record of kind, value byte and token type; the tokenizer's buffer uses its own wider entry type.
	typedef struct packed {
		logic kind;
		logic [7:0] value;
		logic [5:0] ttype;
	} res_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
	endfunction

	function automatic logic [5:0] single_type(input logic [7:0] b);
		logic [5:0] t;
		unique case (b)
			8'h2b: t = 6'd27;
			8'h2d: t = 6'd28;
			8'h2a: t = 6'd29;
			8'h2f: t = 6'd30;
			8'h25: t = 6'd31;
			8'h3d: t = 6'd32;
			8'h3c: t = 6'd33;
			8'h3e: t = 6'd34;
			8'h21: t = 6'd35;
			8'h28: t = 6'd36;
			8'h29: t = 6'd37;
			8'h7b: t = 6'd38;
			8'h7d: t = 6'd39;
			8'h5b: t = 6'd40;
			8'h5d: t = 6'd41;
			8'h2c: t = 6'd42;
			8'h2e: t = 6'd43;
			8'h3a: t = 6'd44;
			8'h3b: t = 6'd45;
			default: t = TOK_NONE;
		endcase
		return t;
	endfunction

	function automatic logic is_pend_start(input logic [7:0] b);
		return (b == 8'h3d) || (b == 8'h21) || (b == 8'h3c) || (b == 8'h3e) ||
			(b == 8'h2d) || (b == 8'h26) || (b == 8'h7c) || (b == 8'h2f);
	endfunction

	function automatic logic [5:0] pair_type(input logic [7:0] a, input logic [7:0] b);
		logic [5:0] t;
		priority if (a == 8'h3d && b == 8'h3d) t = 6'd20;
		else if (a == 8'h21 && b == 8'h3d) t = 6'd21;
		else if (a == 8'h3c && b == 8'h3d) t = 6'd22;
		else if (a == 8'h3e && b == 8'h3d) t = 6'd23;
		else if (a == 8'h2d && b == 8'h3e) t = TOK_ARROW;
		else if (a == 8'h3d && b == 8'h3e) t = TOK_ARROW;
		else if (a == 8'h26 && b == 8'h26) t = 6'd25;
		else if (a == 8'h7c && b == 8'h7c) t = 6'd26;
		else if (a == 8'h2f && b == 8'h2f) t = TOK_COMMENT;
		else t = TOK_NONE;
		return t;
	endfunction

	// Keyword spelling, right aligned in 64 bits, and its length.
	function automatic logic [63:0] kw_text(input int i);
		logic [63:0] s;
		unique case (i)
			0: s = 64'h6c6574;
			1: s = 64'h636f6e7374;
			2: s = 64'h666e;
			3: s = 64'h6966;
			4: s = 64'h656c6966;
			5: s = 64'h656c7365;
			6: s = 64'h666f72;
			7: s = 64'h7768696c65;
			8: s = 64'h696e;
			9: s = 64'h72657475726e;
			10: s = 64'h636c617373;
			11: s = 64'h707562;
			12: s = 64'h70726976;
			13: s = 64'h73656c66;
			14: s = 64'h6e6577;
			15: s = 64'h74727565;
			default: s = 64'h66616c7365;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] kw_len(input int i);
		logic [3:0] n;
		unique case (i)
			0, 6, 11, 14: n = 4'd3;
			2, 3, 8: n = 4'd2;
			4, 5, 12, 13, 15: n = 4'd4;
			9: n = 4'd6;
			default: n = 4'd5;
		endcase
		return n;
	endfunction

endpackage

/* src/source_code_tokenizer_unit.sv */
// ---------------------------------------------------------------------------
// source_code_tokenizer_unit: streaming lexical tokenizer
// Turns a byte stream into token value bytes and token-end records.
// ---------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, byte_value    | into block
//  out     | out_valid, out_stall, result_kind,        | out of block
//          | value_byte, token_type, start_line,       |
//          | start_column, token_length, last_result   |
//
// Each input transaction is decoded combinationally and its results (up to
// four) land in a small result buffer. The buffer drains one result
// transaction per cycle while out_stall is low. A new input transaction
// is taken whenever the buffer has room for four more results. Reset puts
// the lexer back in its idle mode at line 1, column 1 and empties the
// buffer.
module source_code_tokenizer_unit #(
	parameter int LINE_BITS = sct_pkg::LineBitsDefault,
	parameter int COLUMN_BITS = sct_pkg::ColumnBitsDefault,
	parameter int LENGTH_BITS = sct_pkg::LengthBitsDefault,
	parameter int KEYWORD_MAX_LEN = sct_pkg::KeywordMaxLenDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [7:0]             byte_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   result_kind,
	output logic [7:0]             value_byte,
	output logic [5:0]             token_type,
	output logic [LINE_BITS-1:0]   start_line,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic                   last_result
);

	localparam int KwBits = 8 * KEYWORD_MAX_LEN;
	localparam int Depth = 8;

	typedef struct packed {
		logic                   kind;
		logic [7:0]             value;
		logic [5:0]             ttype;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [LENGTH_BITS-1:0] len;
		logic                   last;
	} ent_t;

	// Lexer state.
	sct_pkg::mode_t         mode_q;
	logic [7:0]             pend_q;
	logic [7:0]             quote_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [LINE_BITS-1:0]   tline_q;
	logic [COLUMN_BITS-1:0] tcol_q;
	logic [LENGTH_BITS-1:0] tlen_q;
	logic [KwBits-1:0]      kw_q;

	// Result buffer: a circular queue of eight entries.
	ent_t       buf_q [Depth];
	logic [2:0] rd_q;
	logic [2:0] wr_q;
	logic [3:0] cnt_q;

	logic take;
	logic drain;
	assign in_stall = (cnt_q > 4'd4);
	assign take = in_valid && !in_stall;
	assign out_valid = (cnt_q != 4'd0);
	assign drain = out_valid && !out_stall;

	assign result_kind = buf_q[rd_q].kind;
	assign value_byte = buf_q[rd_q].value;
	assign token_type = buf_q[rd_q].ttype;
	assign start_line = buf_q[rd_q].line;
	assign start_column = buf_q[rd_q].col;
	assign token_length = buf_q[rd_q].len;
	assign last_result = buf_q[rd_q].last;

	// Next-state and result computation for one input.
	sct_pkg::mode_t         mode_d;
	logic [7:0]             pend_d;
	logic [7:0]             quote_d;
	logic [LINE_BITS-1:0]   line_d;
	logic [COLUMN_BITS-1:0] col_d;
	logic [LINE_BITS-1:0]   tline_d;
	logic [COLUMN_BITS-1:0] tcol_d;
	logic [LENGTH_BITS-1:0] tlen_d;
	logic [KwBits-1:0]      kw_d;
	ent_t                   res [4];
	logic [2:0]             nres;
	logic [5:0]             id_type;
	logic [5:0]             pt;
	logic [5:0]             st_pend;
	logic [7:0]             b;
	logic                   restart;

	// Keyword lookup over the held prefix of the identifier.
	always_comb begin
		id_type = sct_pkg::TOK_IDENT;
		if (tlen_q <= LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
			for (int i = sct_pkg::KeywordCount - 1; i >= 0; i--) begin
				if ((LENGTH_BITS'(sct_pkg::kw_len(i)) == tlen_q) &&
						(64'(kw_q) == sct_pkg::kw_text(i))) begin
					id_type = 6'(i);
				end
			end
		end
	end

	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		quote_d = quote_q;
		line_d = line_q;
		col_d = col_q;
		tline_d = tline_q;
		tcol_d = tcol_q;
		tlen_d = tlen_q;
		kw_d = kw_q;
		nres = 3'd0;
		restart = 1'b0;
		b = byte_value;
		for (int k = 0; k < 4; k++) begin
			res[k] = '0;
		end
		pt = sct_pkg::pair_type(pend_q, b);
		st_pend = sct_pkg::single_type(pend_q);

		if (mode_q != sct_pkg::MODE_DONE) begin
			if (opcode == sct_pkg::OP_EOF) begin
				unique case (mode_q)
					sct_pkg::MODE_PEND: begin
						if (st_pend != sct_pkg::TOK_NONE) begin
							tlen_d = (tlen_q == '1) ? tlen_q : tlen_q + 1'b1;
							res[0] = '{sct_pkg::KIND_VALUE, pend_q, 6'd0, tline_q, tcol_q,
								tlen_d, 1'b0};
							res[1] = '{sct_pkg::KIND_END, 8'd0, st_pend, tline_q, tcol_q,
								tlen_d, 1'b0};
							nres = 3'd2;
						end
					end
					sct_pkg::MODE_NUMBER: begin
						res[0] = '{sct_pkg::KIND_END, 8'd0, sct_pkg::TOK_NUMBER, tline_q,
							tcol_q, tlen_q, 1'b0};
						nres = 3'd1;
					end
					sct_pkg::MODE_IDENT: begin
						res[0] = '{sct_pkg::KIND_END, 8'd0, id_type, tline_q, tcol_q,
							tlen_q, 1'b0};
						nres = 3'd1;
					end
					sct_pkg::MODE_STRING, sct_pkg::MODE_ESC: begin
						res[0] = '{sct_pkg::KIND_END, 8'd0, sct_pkg::TOK_STRING, tline_q,
							tcol_q, tlen_q, 1'b0};
						nres = 3'd1;
					end
					default: ;
				endcase
				res[nres[1:0]] = '{sct_pkg::KIND_END, 8'd0, sct_pkg::TOK_EOF, line_q, col_q,
					'0, 1'b0};
				nres = nres + 3'd1;
				mode_d = sct_pkg::MODE_DONE;
			end else begin
				unique case (mode_q)
					sct_pkg::MODE_PEND: begin
						if (pt == sct_pkg::TOK_COMMENT) begin
							mode_d = sct_pkg::MODE_COMMENT;
						end else if (pt != sct_pkg::TOK_NONE) begin
							res[0] = '{sct_pkg::KIND_VALUE, pend_q, 6'd0, tline_q, tcol_q,
								tlen_q + 1'b1, 1'b0};
							res[1] = '{sct_pkg::KIND_VALUE, b, 6'd0, tline_q, tcol_q,
								tlen_q + 2'd2, 1'b0};
							res[2] = '{sct_pkg::KIND_END, 8'd0, pt, tline_q, tcol_q,
								tlen_q + 2'd2, 1'b0};
							tlen_d = tlen_q + 2'd2;
							nres = 3'd3;
							mode_d = sct_pkg::MODE_IDLE;
						end else begin
							if (st_pend != sct_pkg::TOK_NONE) begin
								res[0] = '{sct_pkg::KIND_VALUE, pend_q, 6'd0, tline_q, tcol_q,
									tlen_q + 1'b1, 1'b0};
								res[1] = '{sct_pkg::KIND_END, 8'd0, st_pend, tline_q, tcol_q,
									tlen_q + 1'b1, 1'b0};
								tlen_d = tlen_q + 1'b1;
								nres = 3'd2;
							end
							restart = 1'b1;
						end
					end
					sct_pkg::MODE_NUMBER: begin
						if (sct_pkg::is_digit(b) || b == 8'h2e) begin
							tlen_d = (tlen_q == '1) ? tlen_q : tlen_q + 1'b1;
							res[0] = '{sct_pkg::KIND_VALUE, b, 6'd0, tline_q, tcol_q, tlen_d,
								1'b0};
							nres = 3'd1;
						end else begin
							res[0] = '{sct_pkg::KIND_END, 8'd0, sct_pkg::TOK_NUMBER, tline_q,
								tcol_q, tlen_q, 1'b0};
							nres = 3'd1;
							restart = 1'b1;
						end
					end
					sct_pkg::MODE_IDENT: begin
						if (sct_pkg::is_alpha(b) || sct_pkg::is_digit(b) || b == 8'h5f) begin
							if (tlen_q < LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
								kw_d = {kw_q[KwBits-9:0], b};
							end
							tlen_d = (tlen_q == '1) ? tlen_q : tlen_q + 1'b1;
							res[0] = '{sct_pkg::KIND_VALUE, b, 6'd0, tline_q, tcol_q, tlen_d,
								1'b0};
							nres = 3'd1;
						end else begin
							res[0] = '{sct_pkg::KIND_END, 8'd0, id_type, tline_q, tcol_q,
								tlen_q, 1'b0};
							nres = 3'd1;
							restart = 1'b1;
						end
					end
					sct_pkg::MODE_STRING: begin
						if (b == quote_q) begin
							res[0] = '{sct_pkg::KIND_END, 8'd0, sct_pkg::TOK_STRING, tline_q,
								tcol_q, tlen_q, 1'b0};
							nres = 3'd1;
							mode_d = sct_pkg::MODE_IDLE;
						end else if (b == 8'h5c) begin
							mode_d = sct_pkg::MODE_ESC;
						end else begin
							tlen_d = (tlen_q == '1) ? tlen_q : tlen_q + 1'b1;
							res[0] = '{sct_pkg::KIND_VALUE, b, 6'd0, tline_q, tcol_q, tlen_d,
								1'b0};
							nres = 3'd1;
						end
					end
					sct_pkg::MODE_ESC: begin
						tlen_d = (tlen_q == '1) ? tlen_q : tlen_q + 1'b1;
						res[0] = '{sct_pkg::KIND_VALUE,
							(b == 8'h6e) ? 8'h0a : (b == 8'h74) ? 8'h09 : b,
							6'd0, tline_q, tcol_q, tlen_d, 1'b0};
						nres = 3'd1;
						mode_d = sct_pkg::MODE_STRING;
					end
					sct_pkg::MODE_COMMENT: begin
						if (b == 8'h0a) begin
							mode_d = sct_pkg::MODE_IDLE;
						end
					end
					default: restart = 1'b1;
				endcase

				// Start a new token with this byte. Token lengths here are at most
				// two short, so the saturating cases above never reach this path
				// with a stale length that matters.
				if (restart) begin
					mode_d = sct_pkg::MODE_IDLE;
					if (b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d) begin
						mode_d = sct_pkg::MODE_IDLE;
					end else if (sct_pkg::is_pend_start(b)) begin
						tline_d = line_q;
						tcol_d = col_q;
						tlen_d = '0;
						pend_d = b;
						mode_d = sct_pkg::MODE_PEND;
					end else if (sct_pkg::single_type(b) != sct_pkg::TOK_NONE) begin
						tline_d = line_q;
						tcol_d = col_q;
						tlen_d = LENGTH_BITS'(1);
						res[nres[1:0]] = '{sct_pkg::KIND_VALUE, b, 6'd0, line_q, col_q,
							LENGTH_BITS'(1), 1'b0};
						res[nres[1:0] + 2'd1] = '{sct_pkg::KIND_END, 8'd0,
							sct_pkg::single_type(b), line_q, col_q, LENGTH_BITS'(1), 1'b0};
						nres = nres + 3'd2;
					end else if (b == 8'h22 || b == 8'h27) begin
						tline_d = line_q;
						tcol_d = col_q;
						tlen_d = '0;
						quote_d = b;
						mode_d = sct_pkg::MODE_STRING;
					end else if (sct_pkg::is_digit(b)) begin
						tline_d = line_q;
						tcol_d = col_q;
						tlen_d = LENGTH_BITS'(1);
						res[nres[1:0]] = '{sct_pkg::KIND_VALUE, b, 6'd0, line_q, col_q,
							LENGTH_BITS'(1), 1'b0};
						nres = nres + 3'd1;
						mode_d = sct_pkg::MODE_NUMBER;
					end else if (sct_pkg::is_alpha(b) || b == 8'h5f) begin
						tline_d = line_q;
						tcol_d = col_q;
						tlen_d = LENGTH_BITS'(1);
						kw_d = KwBits'(b);
						res[nres[1:0]] = '{sct_pkg::KIND_VALUE, b, 6'd0, line_q, col_q,
							LENGTH_BITS'(1), 1'b0};
						nres = nres + 3'd1;
						mode_d = sct_pkg::MODE_IDENT;
					end
				end

				// Position of the next byte.
				if (b == 8'h0a) begin
					line_d = (line_q == '1) ? line_q : line_q + 1'b1;
					col_d = COLUMN_BITS'(1);
				end else begin
					col_d = (col_q == '1) ? col_q : col_q + 1'b1;
				end
			end
		end
		if (nres != 3'd0) begin
			res[nres[1:0] - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sct_pkg::MODE_IDLE;
			pend_q <= '0;
			quote_q <= '0;
			line_q <= LINE_BITS'(1);
			col_q <= COLUMN_BITS'(1);
			tline_q <= LINE_BITS'(1);
			tcol_q <= COLUMN_BITS'(1);
			tlen_q <= '0;
			kw_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				pend_q <= pend_d;
				quote_q <= quote_d;
				line_q <= line_d;
				col_q <= col_d;
				tline_q <= tline_d;
				tcol_q <= tcol_d;
				tlen_q <= tlen_d;
				kw_q <= kw_d;
				wr_q <= wr_q + nres;
			end
			if (drain) begin
				rd_q <= rd_q + 3'd1;
			end
			cnt_q <= cnt_q + (take ? {1'b0, nres} : 4'd0) - (drain ? 4'd1 : 4'd0);
		end
	end

	// Result entries carry no reset; the count says which are live.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < nres) begin
					buf_q[wr_q + 3'(k)] <= res[k];
				end
			end
		end
	end

endmodule
